// ===== rtl/mp2d_pkg.sv =====
package mp2d_pkg;

  localparam int PIXEL_W   = 32;
  localparam int OUT_ROW_W = 13;
  localparam int OUT_COL_W = 9;

  localparam int HREG_W     = 13;
  localparam int WREG_W     = 9;
  localparam int KREG_W     = 4;
  localparam int PREG_W     = 3;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 4;

  localparam logic [PIXEL_W-1:0] NEG_FLT_MAX = 32'hFF7F_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_HEIGHT   = 4'd0,
    REG_IN_WIDTH    = 4'd1,
    REG_KERNEL_ROWS = 4'd2,
    REG_KERNEL_COLS = 4'd3,
    REG_STRIDE_ROWS = 4'd4,
    REG_STRIDE_COLS = 4'd5,
    REG_PAD_ROWS    = 4'd6,
    REG_PAD_COLS    = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    A_IDLE,
    A_CAP,
    A_LO,
    A_DONE
  } axis_state_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPAN,
    S_RD,
    S_UPD
  } seq_state_e;

  // Ordered IEEE single compare: true when a > b, never true with a NaN.
  function automatic logic f32_gt(input logic [PIXEL_W-1:0] a, input logic [PIXEL_W-1:0] b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    logic res;
    a_nan     = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan     = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
    if (a_nan || b_nan || both_zero) begin
      res = 1'b0;
    end else if (!a[31] && b[31]) begin
      res = 1'b1;
    end else if (a[31] && !b[31]) begin
      res = 1'b0;
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/mp2d_if.sv =====
interface mp2d_in_if;
  logic                         valid;
  logic                         ready;
  logic [mp2d_pkg::PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface mp2d_out_if;
  logic                           valid;
  logic                           ready;
  logic [mp2d_pkg::PIXEL_W-1:0]   pooled;
  logic [mp2d_pkg::OUT_ROW_W-1:0] out_row;
  logic [mp2d_pkg::OUT_COL_W-1:0] out_col;
  logic                           plane_end;
  logic                           run_last;

  modport source (output valid, output pooled, output out_row, output out_col,
                  output plane_end, output run_last, input ready);
  modport sink (input valid, input pooled, input out_row, input out_col,
                input plane_end, input run_last, output ready);
endinterface

// ===== rtl/mp2d_ram.sv =====
module mp2d_ram #(
  parameter int DW    = 32,
  parameter int DEPTH = 2056,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mp2d_axis.sv =====
module mp2d_axis #(
  parameter int NMAX       = 256,
  parameter int NREGW      = 9,
  parameter int MAX_KERNEL = 8,
  parameter int MAX_STRIDE = 8,
  localparam int XW  = $clog2(NMAX),
  localparam int NW  = $clog2(NMAX + 1),
  localparam int QW  = NW + 1,
  localparam int STW = NW + 3,
  localparam int KW  = $clog2(MAX_KERNEL + 1),
  localparam int SW  = $clog2(MAX_STRIDE + 1),
  localparam int PW  = $clog2(MAX_KERNEL / 2 + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [NREGW-1:0]              n_raw_i,
  input  logic [mp2d_pkg::KREG_W-1:0]   k_raw_i,
  input  logic [mp2d_pkg::KREG_W-1:0]   s_raw_i,
  input  logic [mp2d_pkg::PREG_W-1:0]   p_raw_i,
  input  logic                          restart_i,
  input  logic                          start_i,
  input  logic                          advance_i,
  output logic [XW-1:0]                 pos_o,
  output logic [NW-1:0]                 n_o,
  output logic [KW-1:0]                 k_o,
  output logic [SW-1:0]                 s_o,
  output logic [PW-1:0]                 p_o,
  output logic                          wrap_o,
  output logic                          done_o,
  output logic                          empty_o,
  output logic [QW-1:0]                 lo_idx_o,
  output logic [QW-1:0]                 hi_idx_o,
  output logic signed [STW-1:0]         lo_start_o
);

  localparam int RW = (SW > PW) ? SW : PW;
  localparam logic signed [STW-1:0] ONE_S = 1;

  logic [NW-1:0] n_eff;
  logic [KW-1:0] k_eff;
  logic [SW-1:0] s_eff;
  logic [PW-1:0] p_eff;

  // Clamp the raw settings; pad is limited to half the kernel and the kernel
  // to the padded extent.
  always_comb begin
    int nc;
    int kc;
    int sc;
    int pc;
    nc = int'(n_raw_i);
    if (nc < 1) nc = 1;
    else if (nc > NMAX) nc = NMAX;
    kc = int'(k_raw_i);
    if (kc < 1) kc = 1;
    else if (kc > MAX_KERNEL) kc = MAX_KERNEL;
    sc = int'(s_raw_i);
    if (sc < 1) sc = 1;
    else if (sc > MAX_STRIDE) sc = MAX_STRIDE;
    pc = int'(p_raw_i);
    if (pc > (kc >> 1)) pc = kc >> 1;
    if (nc + 2 * pc < kc) kc = nc + 2 * pc;
    n_eff = NW'(nc);
    k_eff = KW'(kc);
    s_eff = SW'(sc);
    p_eff = PW'(pc);
  end

  // Window index and phase at position zero: pad divided by stride.
  logic [QW-1:0] q0;
  logic [RW-1:0] rem0;

  always_comb begin
    rem0 = RW'(p_eff);
    q0   = '0;
    for (int i = 0; i < MAX_KERNEL / 2; i++) begin
      if (rem0 >= RW'(s_eff)) begin
        rem0 = rem0 - RW'(s_eff);
        q0   = q0 + 1'b1;
      end
    end
  end

  logic [XW-1:0] pos_q, pos_d;
  logic [QW-1:0] q_q, q_d;
  logic [RW-1:0] rem_q, rem_d;
  logic [QW-1:0] q_cur;
  logic [RW-1:0] rem_cur;
  logic [RW:0]   rem_inc;

  assign q_cur   = (pos_q == '0) ? q0 : q_q;
  assign rem_cur = (pos_q == '0) ? rem0 : rem_q;
  assign rem_inc = {1'b0, rem_cur} + 1'b1;
  assign wrap_o  = ({1'b0, NW'(pos_q)} + 1'b1) >= {1'b0, n_eff};

  // q and rem track floor((pos + pad) / stride) and its remainder.
  always_comb begin
    pos_d = pos_q;
    q_d   = q_q;
    rem_d = rem_q;
    if (restart_i) begin
      pos_d = '0;
    end else if (advance_i) begin
      if (wrap_o) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (rem_inc == (RW + 1)'(s_eff)) begin
          rem_d = '0;
          q_d   = q_cur + 1'b1;
        end else begin
          rem_d = rem_inc[RW-1:0];
          q_d   = q_cur;
        end
      end
    end
  end

  mp2d_pkg::axis_state_e state_q, state_d;
  logic [QW-1:0]         idx_q, idx_d;
  logic [QW-1:0]         hi_q, hi_d;
  logic signed [STW-1:0] st_q, st_d;
  logic                  empty_q, empty_d;

  logic signed [STW-1:0] x_s, k_s, s_s, lim_s, end_s, prev_end_s;

  assign x_s        = $signed(STW'(pos_q));
  assign k_s        = $signed(STW'(k_eff));
  assign s_s        = $signed(STW'(s_eff));
  assign lim_s      = $signed(STW'(n_eff)) - ONE_S + $signed(STW'(p_eff));
  assign end_s      = st_q + k_s - ONE_S;
  assign prev_end_s = end_s - s_s;

  always_comb begin
    state_d = state_q;
    if (start_i) begin
      state_d = mp2d_pkg::A_CAP;
    end else begin
      unique case (state_q)
        mp2d_pkg::A_IDLE: state_d = mp2d_pkg::A_IDLE;
        mp2d_pkg::A_CAP: begin
          if (end_s > lim_s) begin
            if (idx_q == '0) state_d = mp2d_pkg::A_DONE;
          end else begin
            state_d = mp2d_pkg::A_LO;
          end
        end
        mp2d_pkg::A_LO: begin
          if (end_s < x_s) begin
            state_d = mp2d_pkg::A_DONE;
          end else if (!(idx_q != '0 && prev_end_s >= x_s)) begin
            state_d = mp2d_pkg::A_DONE;
          end
        end
        mp2d_pkg::A_DONE: state_d = mp2d_pkg::A_DONE;
        default: state_d = mp2d_pkg::A_IDLE;
      endcase
    end
  end

  // Walk down from the window that starts at or before pos: first past the
  // windows that overrun the padded plane, then to the lowest one holding pos.
  always_comb begin
    idx_d   = idx_q;
    hi_d    = hi_q;
    st_d    = st_q;
    empty_d = empty_q;
    if (start_i) begin
      idx_d   = q_cur;
      st_d    = x_s - $signed(STW'(rem_cur));
      empty_d = 1'b0;
    end else begin
      unique case (state_q)
        mp2d_pkg::A_CAP: begin
          if (end_s > lim_s) begin
            if (idx_q != '0) begin
              idx_d = idx_q - 1'b1;
              st_d  = st_q - s_s;
            end else begin
              empty_d = 1'b1;
            end
          end else begin
            hi_d = idx_q;
          end
        end
        mp2d_pkg::A_LO: begin
          if (end_s < x_s) begin
            empty_d = 1'b1;
          end else if (idx_q != '0 && prev_end_s >= x_s) begin
            idx_d = idx_q - 1'b1;
            st_d  = st_q - s_s;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mp2d_pkg::A_IDLE;
      pos_q   <= '0;
      q_q     <= '0;
      rem_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      q_q     <= q_d;
      rem_q   <= rem_d;
      empty_q <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    hi_q  <= hi_d;
    st_q  <= st_d;
  end

  assign pos_o      = pos_q;
  assign n_o        = n_eff;
  assign k_o        = k_eff;
  assign s_o        = s_eff;
  assign p_o        = p_eff;
  assign done_o     = (state_q == mp2d_pkg::A_DONE);
  assign empty_o    = empty_q;
  assign lo_idx_o   = idx_q;
  assign hi_idx_o   = hi_q;
  assign lo_start_o = st_q;

endmodule

// ===== rtl/max_pool_2d_stream_core.sv =====
// Streaming 2D max pooling of float32 pixels, one plane after another in
// raster order. A pixel is taken only while the block is idle; it is then
// registered, the row and column window searches run in parallel, and
// every output window that covers the pixel gets one window store read,
// then one compare and write back. The single port of the window store and
// the one float compare set this pace. A stalled output holds the walk only
// when another finished window must go out. A write to one of the eight
// configuration registers restarts the plane at row 0, column 0; spare
// indexes are ignored.
module max_pool_2d_stream_core #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_KERNEL = 8,
  parameter int MAX_STRIDE = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mp2d_in_if.sink                           px_in,
  mp2d_out_if.source                        pool_out
);

  localparam int XW_R  = $clog2(MAX_HEIGHT);
  localparam int NW_R  = $clog2(MAX_HEIGHT + 1);
  localparam int QW_R  = NW_R + 1;
  localparam int STW_R = NW_R + 3;
  localparam int XW_C  = $clog2(MAX_WIDTH);
  localparam int NW_C  = $clog2(MAX_WIDTH + 1);
  localparam int QW_C  = NW_C + 1;
  localparam int STW_C = NW_C + 3;
  localparam int KW    = $clog2(MAX_KERNEL + 1);
  localparam int SW    = $clog2(MAX_STRIDE + 1);
  localparam int PW    = $clog2(MAX_KERNEL / 2 + 1);
  localparam int SRB   = $clog2(MAX_KERNEL);
  localparam int SLOT_COLS = MAX_WIDTH + 1;
  localparam int DEPTH = (1 << SRB) * SLOT_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [STW_R-1:0] ONE_R = 1;
  localparam logic signed [STW_C-1:0] ONE_C = 1;

  // Configuration registers.
  logic [mp2d_pkg::HREG_W-1:0] in_height_q;
  logic [mp2d_pkg::WREG_W-1:0] in_width_q;
  logic [mp2d_pkg::KREG_W-1:0] kernel_rows_q, kernel_cols_q;
  logic [mp2d_pkg::KREG_W-1:0] stride_rows_q, stride_cols_q;
  logic [mp2d_pkg::PREG_W-1:0] pad_rows_q, pad_cols_q;
  logic                        cfg_hit;

  always_comb begin
    unique case (mp2d_pkg::cfg_reg_e'(cfg_idx_i))
      mp2d_pkg::REG_IN_HEIGHT, mp2d_pkg::REG_IN_WIDTH,
      mp2d_pkg::REG_KERNEL_ROWS, mp2d_pkg::REG_KERNEL_COLS,
      mp2d_pkg::REG_STRIDE_ROWS, mp2d_pkg::REG_STRIDE_COLS,
      mp2d_pkg::REG_PAD_ROWS, mp2d_pkg::REG_PAD_COLS: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q   <= mp2d_pkg::HREG_W'(1);
      in_width_q    <= mp2d_pkg::WREG_W'(1);
      kernel_rows_q <= mp2d_pkg::KREG_W'(2);
      kernel_cols_q <= mp2d_pkg::KREG_W'(2);
      stride_rows_q <= mp2d_pkg::KREG_W'(2);
      stride_cols_q <= mp2d_pkg::KREG_W'(2);
      pad_rows_q    <= '0;
      pad_cols_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (mp2d_pkg::cfg_reg_e'(cfg_idx_i))
        mp2d_pkg::REG_IN_HEIGHT:   in_height_q   <= cfg_data_i[mp2d_pkg::HREG_W-1:0];
        mp2d_pkg::REG_IN_WIDTH:    in_width_q    <= cfg_data_i[mp2d_pkg::WREG_W-1:0];
        mp2d_pkg::REG_KERNEL_ROWS: kernel_rows_q <= cfg_data_i[mp2d_pkg::KREG_W-1:0];
        mp2d_pkg::REG_KERNEL_COLS: kernel_cols_q <= cfg_data_i[mp2d_pkg::KREG_W-1:0];
        mp2d_pkg::REG_STRIDE_ROWS: stride_rows_q <= cfg_data_i[mp2d_pkg::KREG_W-1:0];
        mp2d_pkg::REG_STRIDE_COLS: stride_cols_q <= cfg_data_i[mp2d_pkg::KREG_W-1:0];
        mp2d_pkg::REG_PAD_ROWS:    pad_rows_q    <= cfg_data_i[mp2d_pkg::PREG_W-1:0];
        mp2d_pkg::REG_PAD_COLS:    pad_cols_q    <= cfg_data_i[mp2d_pkg::PREG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Row and column trackers.
  logic                     axis_start, col_adv, row_adv;
  logic [XW_R-1:0]          row_pos;
  logic [NW_R-1:0]          row_n;
  logic [KW-1:0]            row_k, col_k;
  logic [SW-1:0]            row_s, col_s;
  logic [PW-1:0]            row_p, col_p;
  logic                     row_wrap, row_done, row_empty;
  logic [QW_R-1:0]          row_lo, row_hi;
  logic signed [STW_R-1:0]  row_lo_st;
  logic [XW_C-1:0]          col_pos;
  logic [NW_C-1:0]          col_n;
  logic                     col_wrap, col_done, col_empty;
  logic [QW_C-1:0]          col_lo, col_hi;
  logic signed [STW_C-1:0]  col_lo_st;

  assign row_adv = col_adv && col_wrap;

  mp2d_axis #(
    .NMAX(MAX_HEIGHT), .NREGW(mp2d_pkg::HREG_W),
    .MAX_KERNEL(MAX_KERNEL), .MAX_STRIDE(MAX_STRIDE)
  ) u_row (
    .clk_i, .rst_ni,
    .n_raw_i(in_height_q), .k_raw_i(kernel_rows_q), .s_raw_i(stride_rows_q),
    .p_raw_i(pad_rows_q), .restart_i(cfg_hit), .start_i(axis_start),
    .advance_i(row_adv), .pos_o(row_pos), .n_o(row_n), .k_o(row_k), .s_o(row_s),
    .p_o(row_p), .wrap_o(row_wrap), .done_o(row_done), .empty_o(row_empty),
    .lo_idx_o(row_lo), .hi_idx_o(row_hi), .lo_start_o(row_lo_st)
  );

  mp2d_axis #(
    .NMAX(MAX_WIDTH), .NREGW(mp2d_pkg::WREG_W),
    .MAX_KERNEL(MAX_KERNEL), .MAX_STRIDE(MAX_STRIDE)
  ) u_col (
    .clk_i, .rst_ni,
    .n_raw_i(in_width_q), .k_raw_i(kernel_cols_q), .s_raw_i(stride_cols_q),
    .p_raw_i(pad_cols_q), .restart_i(cfg_hit), .start_i(axis_start),
    .advance_i(col_adv), .pos_o(col_pos), .n_o(col_n), .k_o(col_k), .s_o(col_s),
    .p_o(col_p), .wrap_o(col_wrap), .done_o(col_done), .empty_o(col_empty),
    .lo_idx_o(col_lo), .hi_idx_o(col_hi), .lo_start_o(col_lo_st)
  );

  // Sequencer and window walk.
  mp2d_pkg::seq_state_e state_q, state_d;
  logic [mp2d_pkg::PIXEL_W-1:0] pix_q;
  logic [QW_R-1:0]              oh_q;
  logic [QW_C-1:0]              ow_q;
  logic signed [STW_R-1:0]      rs_q;
  logic signed [STW_C-1:0]      cs_q;
  logic                         out_valid_q;
  logic [mp2d_pkg::PIXEL_W-1:0] pooled_q;
  logic [mp2d_pkg::OUT_ROW_W-1:0] out_row_q;
  logic [mp2d_pkg::OUT_COL_W-1:0] out_col_q;
  logic                         plane_end_q, run_last_q;

  logic                    spans_ready, span_empty, last_pair;
  logic                    r_first, r_last, c_first, c_last, emit, stall;
  logic                    row_final, col_final, run_end;
  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_addr;
  logic [mp2d_pkg::PIXEL_W-1:0] ram_rdata, cur_max, new_max;
  logic signed [STW_R-1:0] r_s, kr_s, sr_s, nr_m1, limr_s;
  logic signed [STW_C-1:0] c_s, kc_s, sc_s, nc_m1, limc_s;

  assign spans_ready = row_done && col_done;
  assign span_empty  = row_empty || col_empty;
  assign last_pair   = (ow_q == col_hi) && (oh_q == row_hi);

  assign r_s    = $signed(STW_R'(row_pos));
  assign kr_s   = $signed(STW_R'(row_k));
  assign sr_s   = $signed(STW_R'(row_s));
  assign nr_m1  = $signed(STW_R'(row_n)) - ONE_R;
  assign limr_s = nr_m1 + $signed(STW_R'(row_p));
  assign c_s    = $signed(STW_C'(col_pos));
  assign kc_s   = $signed(STW_C'(col_k));
  assign sc_s   = $signed(STW_C'(col_s));
  assign nc_m1  = $signed(STW_C'(col_n)) - ONE_C;
  assign limc_s = nc_m1 + $signed(STW_C'(col_p));

  // The pixel opens a window at its first in-image position and closes it at
  // its last one; the window start never exceeds the pixel position.
  assign r_first = (rs_q == r_s) || (row_pos == '0);
  assign c_first = (cs_q == c_s) || (col_pos == '0);
  assign r_last  = (rs_q + kr_s - ONE_R == r_s) || (r_s == nr_m1);
  assign c_last  = (cs_q + kc_s - ONE_C == c_s) || (c_s == nc_m1);
  assign emit    = r_last && c_last;

  // Windows closed by one pixel are either only the lowest or all of the
  // span on each axis, so the final one is known up front.
  assign row_final = (rs_q + sr_s + kr_s - ONE_R) > limr_s;
  assign col_final = (cs_q + sc_s + kc_s - ONE_C) > limc_s;
  assign run_end   = (oh_q == ((r_s == nr_m1) ? row_hi : row_lo)) &&
                     (ow_q == ((c_s == nc_m1) ? col_hi : col_lo));

  assign stall   = emit && out_valid_q && !pool_out.ready;
  assign cur_max = (r_first && c_first) ? mp2d_pkg::NEG_FLT_MAX : ram_rdata;
  assign new_max = mp2d_pkg::f32_gt(pix_q, cur_max) ? pix_q : cur_max;

  assign ram_addr = AW'(oh_q[SRB-1:0]) * AW'(SLOT_COLS) + AW'(ow_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mp2d_pkg::S_IDLE: if (px_in.valid) state_d = mp2d_pkg::S_SPAN;
      mp2d_pkg::S_SPAN: begin
        if (spans_ready) state_d = span_empty ? mp2d_pkg::S_IDLE : mp2d_pkg::S_RD;
      end
      mp2d_pkg::S_RD: state_d = mp2d_pkg::S_UPD;
      mp2d_pkg::S_UPD: begin
        if (!stall) state_d = last_pair ? mp2d_pkg::S_IDLE : mp2d_pkg::S_RD;
      end
      default: state_d = mp2d_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    px_in.ready = 1'b0;
    axis_start  = 1'b0;
    col_adv     = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    unique case (state_q)
      mp2d_pkg::S_IDLE: begin
        px_in.ready = 1'b1;
        axis_start  = px_in.valid;
      end
      mp2d_pkg::S_SPAN: col_adv = spans_ready && span_empty;
      mp2d_pkg::S_RD:   ram_re = 1'b1;
      mp2d_pkg::S_UPD: begin
        ram_we  = !stall;
        col_adv = !stall && last_pair;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mp2d_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mp2d_pkg::S_UPD && emit && !stall) begin
        out_valid_q <= 1'b1;
      end else if (pool_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mp2d_pkg::S_IDLE && px_in.valid) begin
      pix_q <= px_in.pixel;
    end
    if (state_q == mp2d_pkg::S_SPAN && spans_ready) begin
      oh_q <= row_lo;
      rs_q <= row_lo_st;
      ow_q <= col_lo;
      cs_q <= col_lo_st;
    end else if (state_q == mp2d_pkg::S_UPD && !stall && !last_pair) begin
      if (ow_q == col_hi) begin
        ow_q <= col_lo;
        cs_q <= col_lo_st;
        oh_q <= oh_q + 1'b1;
        rs_q <= rs_q + sr_s;
      end else begin
        ow_q <= ow_q + 1'b1;
        cs_q <= cs_q + sc_s;
      end
    end
    if (state_q == mp2d_pkg::S_UPD && emit && !stall) begin
      pooled_q    <= new_max;
      out_row_q   <= mp2d_pkg::OUT_ROW_W'(oh_q);
      out_col_q   <= mp2d_pkg::OUT_COL_W'(ow_q);
      plane_end_q <= row_final && col_final;
      run_last_q  <= run_end;
    end
  end

  mp2d_ram #(
    .DW(mp2d_pkg::PIXEL_W),
    .DEPTH(DEPTH)
  ) u_win_ram (
    .clk_i,
    .we_i(ram_we),
    .re_i(ram_re),
    .addr_i(ram_addr),
    .wdata_i(new_max),
    .rdata_o(ram_rdata)
  );

  assign pool_out.valid     = out_valid_q;
  assign pool_out.pooled    = pooled_q;
  assign pool_out.out_row   = out_row_q;
  assign pool_out.out_col   = out_col_q;
  assign pool_out.plane_end = plane_end_q;
  assign pool_out.run_last  = run_last_q;

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NW_C'(col_pos) < col_n)
    else $error("column position outside the plane");

  a_row_wrap_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_wrap |-> (NW_R'(row_pos) == row_n - 1'b1))
    else $error("row wrap away from the last row");

  a_accept_starts_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (px_in.valid && px_in.ready) |=> (state_q == mp2d_pkg::S_SPAN))
    else $error("accepted pixel did not start the span search");

  a_result_from_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == mp2d_pkg::S_UPD))
    else $error("result raised outside a window update");

  a_walk_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mp2d_pkg::S_RD) |-> !(row_empty || col_empty))
    else $error("window walk entered with an empty span");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

  localparam int MAX_W      = 256;
  localparam int MAX_H      = 4096;
  localparam int MAX_K      = 8;
  localparam int MAX_S      = 8;
  localparam int SLOT_COLS  = MAX_W + 1;
  localparam int DRAIN_WAIT = 200;
  localparam int STALL_LIMIT = 6000;
  localparam int PHASE_PIXELS = 17;
  localparam int NUM_PHASES   = 8;
  localparam int NUM_CORNER   = 9;
  localparam logic [mp2d_pkg::CFG_IDX_W-1:0] FIRST_SPARE_IDX = 4'd8;
  localparam logic [mp2d_pkg::CFG_IDX_W-1:0] LAST_SPARE_IDX  = '1;
  localparam logic [mp2d_pkg::PIXEL_W-1:0] CORNER_PIXELS [NUM_CORNER] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000, 32'h7F80_0000,
    32'hFF80_0000, mp2d_pkg::NEG_FLT_MAX, 32'h7F7F_FFFF, 32'hFFFF_FFFF,
    32'h0000_0001};

  typedef struct {
    int n, k, s, p, o;
  } pool_axis_t;

  typedef struct {
    logic [mp2d_pkg::PIXEL_W-1:0]   pooled;
    logic [mp2d_pkg::OUT_ROW_W-1:0] out_row;
    logic [mp2d_pkg::OUT_COL_W-1:0] out_col;
    logic                           plane_end;
    logic                           run_last;
  } window_result_t;

  class pool_scoreboard;
    logic [mp2d_pkg::CFG_DATA_W-1:0] regs[8];
    logic [mp2d_pkg::PIXEL_W-1:0]    window_max[MAX_K*SLOT_COLS];
    int                              cur_row;
    int                              cur_col;
    window_result_t                  expected_windows[$];
    int                              errors;

    function new();
      regs[mp2d_pkg::REG_IN_HEIGHT]   = mp2d_pkg::CFG_DATA_W'(1);
      regs[mp2d_pkg::REG_IN_WIDTH]    = mp2d_pkg::CFG_DATA_W'(1);
      regs[mp2d_pkg::REG_KERNEL_ROWS] = mp2d_pkg::CFG_DATA_W'(2);
      regs[mp2d_pkg::REG_KERNEL_COLS] = mp2d_pkg::CFG_DATA_W'(2);
      regs[mp2d_pkg::REG_STRIDE_ROWS] = mp2d_pkg::CFG_DATA_W'(2);
      regs[mp2d_pkg::REG_STRIDE_COLS] = mp2d_pkg::CFG_DATA_W'(2);
      regs[mp2d_pkg::REG_PAD_ROWS]    = '0;
      regs[mp2d_pkg::REG_PAD_COLS]    = '0;
      foreach (window_max[i]) window_max[i] = '0;
      cur_row = 0;
      cur_col = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [mp2d_pkg::CFG_IDX_W-1:0] idx,
                            logic [mp2d_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        mp2d_pkg::REG_IN_HEIGHT: regs[idx] = val;
        mp2d_pkg::REG_IN_WIDTH:
          regs[idx] = mp2d_pkg::CFG_DATA_W'(val[mp2d_pkg::WREG_W-1:0]);
        mp2d_pkg::REG_KERNEL_ROWS, mp2d_pkg::REG_KERNEL_COLS,
        mp2d_pkg::REG_STRIDE_ROWS, mp2d_pkg::REG_STRIDE_COLS:
          regs[idx] = mp2d_pkg::CFG_DATA_W'(val[mp2d_pkg::KREG_W-1:0]);
        mp2d_pkg::REG_PAD_ROWS, mp2d_pkg::REG_PAD_COLS:
          regs[idx] = mp2d_pkg::CFG_DATA_W'(val[mp2d_pkg::PREG_W-1:0]);
        default: return;
      endcase
      cur_row = 0;
      cur_col = 0;
    endfunction

    function int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function pool_axis_t axis_geometry(int n, int k, int s, int p, int nmax);
      pool_axis_t a;
      a.n = clip(n, 1, nmax);
      a.k = clip(k, 1, MAX_K);
      a.s = clip(s, 1, MAX_S);
      a.p = p;
      if (a.p > a.k / 2) a.p = a.k / 2;
      if (a.n + 2 * a.p < a.k) a.k = a.n + 2 * a.p;
      a.o = (a.n + 2 * a.p - a.k) / a.s + 1;
      return a;
    endfunction

    // Maps a float pattern onto an unsigned key whose order is the float order.
    function logic [31:0] order_key(logic [31:0] f);
      if (f[30:0] == 0) f = '0;
      return f[31] ? ~f : (f | 32'h8000_0000);
    endfunction

    function bit is_nan(logic [31:0] f);
      return f[30:23] == 8'hFF && f[22:0] != 0;
    endfunction

    function bit float_above(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 0;
      return order_key(a) > order_key(b);
    endfunction

    function void note_pixel(logic [mp2d_pkg::PIXEL_W-1:0] pix);
      pool_axis_t ra, ca;
      int lo_r, hi_r, lo_c, hi_c, t, rs, cs, idx, count;
      window_result_t w;
      ra = axis_geometry(int'(regs[mp2d_pkg::REG_IN_HEIGHT]),
                         int'(regs[mp2d_pkg::REG_KERNEL_ROWS]),
                         int'(regs[mp2d_pkg::REG_STRIDE_ROWS]),
                         int'(regs[mp2d_pkg::REG_PAD_ROWS]), MAX_H);
      ca = axis_geometry(int'(regs[mp2d_pkg::REG_IN_WIDTH]),
                         int'(regs[mp2d_pkg::REG_KERNEL_COLS]),
                         int'(regs[mp2d_pkg::REG_STRIDE_COLS]),
                         int'(regs[mp2d_pkg::REG_PAD_COLS]), MAX_W);
      if (cur_row >= ra.n || cur_col >= ca.n) begin
        cur_row = 0;
        cur_col = 0;
      end
      t = cur_row + ra.p - ra.k + 1;
      lo_r = t <= 0 ? 0 : (t + ra.s - 1) / ra.s;
      hi_r = (cur_row + ra.p) / ra.s;
      if (hi_r > ra.o - 1) hi_r = ra.o - 1;
      t = cur_col + ca.p - ca.k + 1;
      lo_c = t <= 0 ? 0 : (t + ca.s - 1) / ca.s;
      hi_c = (cur_col + ca.p) / ca.s;
      if (hi_c > ca.o - 1) hi_c = ca.o - 1;
      count = 0;
      for (int oh = lo_r; oh <= hi_r; oh++) begin
        rs = oh * ra.s - ra.p;
        for (int ow = lo_c; ow <= hi_c; ow++) begin
          cs = ow * ca.s - ca.p;
          idx = (oh % MAX_K) * SLOT_COLS + ow;
          if (cur_row == (rs < 0 ? 0 : rs) && cur_col == (cs < 0 ? 0 : cs))
            window_max[idx] = mp2d_pkg::NEG_FLT_MAX;
          if (float_above(pix, window_max[idx])) window_max[idx] = pix;
          if (cur_row == clip(rs + ra.k - 1, rs, ra.n - 1) &&
              cur_col == clip(cs + ca.k - 1, cs, ca.n - 1)) begin
            w.pooled    = window_max[idx];
            w.out_row   = oh[mp2d_pkg::OUT_ROW_W-1:0];
            w.out_col   = ow[mp2d_pkg::OUT_COL_W-1:0];
            w.plane_end = (oh == ra.o - 1) && (ow == ca.o - 1);
            w.run_last  = 1'b0;
            expected_windows.push_back(w);
            count++;
          end
        end
      end
      if (count > 0) expected_windows[$].run_last = 1'b1;
      cur_col++;
      if (cur_col >= ca.n) begin
        cur_col = 0;
        cur_row++;
        if (cur_row >= ra.n) cur_row = 0;
      end
    endfunction

    function void check_result(window_result_t got);
      window_result_t exp;
      if (expected_windows.size() == 0) begin
        $error("unexpected window beat: pooled %h row %0d col %0d",
               got.pooled, got.out_row, got.out_col);
        errors++;
        return;
      end
      exp = expected_windows.pop_front();
      if (got.pooled !== exp.pooled) begin
        $error("pooled: expected %h, got %h", exp.pooled, got.pooled); errors++;
      end
      if (got.out_row !== exp.out_row) begin
        $error("out_row: expected %0d, got %0d", exp.out_row, got.out_row); errors++;
      end
      if (got.out_col !== exp.out_col) begin
        $error("out_col: expected %0d, got %0d", exp.out_col, got.out_col); errors++;
      end
      if (got.plane_end !== exp.plane_end) begin
        $error("plane_end: expected %b, got %b", exp.plane_end, got.plane_end); errors++;
      end
      if (got.run_last !== exp.run_last) begin
        $error("run_last: expected %b, got %b", exp.run_last, got.run_last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  pool_scoreboard pool_sb = new();

  mp2d_in_if  px_if ();
  mp2d_out_if win_if ();

  max_pool_2d_stream_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .px_in      (px_if.sink),
    .pool_out   (win_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    px_if.valid = 1'b0;
    px_if.pixel = '0;
    win_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    window_result_t got;
    if (rst_ni && win_if.valid && win_if.ready) begin
      got.pooled    = win_if.pooled;
      got.out_row   = win_if.out_row;
      got.out_col   = win_if.out_col;
      got.plane_end = win_if.plane_end;
      got.run_last  = win_if.run_last;
      pool_sb.check_result(got);
    end
    win_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((px_if.valid && px_if.ready) || (win_if.valid && win_if.ready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("max_pool_2d_stream_core regression: fail");
      $finish;
    end
  end

  task automatic set_reg(logic [mp2d_pkg::CFG_IDX_W-1:0] idx,
                         logic [mp2d_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    pool_sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_geometry(int h, int w, int kr, int kc, int sr, int sc, int pr, int pc);
    set_reg(mp2d_pkg::REG_IN_HEIGHT, mp2d_pkg::CFG_DATA_W'(h));
    set_reg(mp2d_pkg::REG_IN_WIDTH, mp2d_pkg::CFG_DATA_W'(w));
    set_reg(mp2d_pkg::REG_KERNEL_ROWS, mp2d_pkg::CFG_DATA_W'(kr));
    set_reg(mp2d_pkg::REG_KERNEL_COLS, mp2d_pkg::CFG_DATA_W'(kc));
    set_reg(mp2d_pkg::REG_STRIDE_ROWS, mp2d_pkg::CFG_DATA_W'(sr));
    set_reg(mp2d_pkg::REG_STRIDE_COLS, mp2d_pkg::CFG_DATA_W'(sc));
    set_reg(mp2d_pkg::REG_PAD_ROWS, mp2d_pkg::CFG_DATA_W'(pr));
    set_reg(mp2d_pkg::REG_PAD_COLS, mp2d_pkg::CFG_DATA_W'(pc));
  endtask

  task automatic send_pixel(logic [mp2d_pkg::PIXEL_W-1:0] pix);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      px_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    px_if.valid <= 1'b1;
    px_if.pixel <= pix;
    do @(posedge clk_i); while (!px_if.ready);
    pool_sb.note_pixel(pix);
  endtask

  // Lets the block settle after the last window, since a pixel may still be
  // in flight without causing any result.
  task automatic drain();
    @(posedge clk_i);
    px_if.valid <= 1'b0;
    while (pool_sb.expected_windows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [mp2d_pkg::PIXEL_W-1:0] random_pixel();
    logic [mp2d_pkg::PIXEL_W-1:0] specials[8] = '{32'h0000_0000, 32'h8000_0000,
      32'h7FC0_0000, 32'h7F80_0000, 32'hFF80_0000, mp2d_pkg::NEG_FLT_MAX,
      32'h7F7F_FFFF, 32'hFFFF_FFFF};
    int pick;
    pick = $urandom_range(99);
    if (pick < 15) return specials[$urandom_range(7)];
    if (pick < 40) return $urandom;
    return {1'($urandom), 8'($urandom_range(150, 100)), 23'($urandom)};
  endfunction

  initial begin
    int mode;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset geometry: one pixel plane, kernel lowered to one.
    send_pixel(32'h3F80_0000);
    drain();

    // Padded 3x3 plane with overlapping windows and every special value.
    set_geometry(3, 3, 2, 2, 1, 1, 1, 1);
    for (int i = 0; i < NUM_CORNER; i++) send_pixel(CORNER_PIXELS[i]);
    drain();

    // Out-of-range values get clamped; spare indexes must be ignored.
    set_geometry(0, 511, 15, 0, 15, 0, 7, 7);
    set_reg(FIRST_SPARE_IDX, 13'h1FFF);
    set_reg(LAST_SPARE_IDX, 13'h0AAA);
    repeat (4) send_pixel(random_pixel());
    drain();
    set_geometry(8191, 256, 8, 8, 8, 8, 4, 4);
    repeat (3) send_pixel(random_pixel());
    drain();

    // Stride past the kernel leaves rows and columns outside every window.
    set_geometry(4, 5, 1, 1, 3, 3, 0, 0);
    repeat (6) send_pixel(random_pixel());
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      mode = ph % 4;
      idle_pct  = (mode == 1 || mode == 3) ? (mode == 1 ? 73 : 33) : 0;
      stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 73 : 33) : 0;
      if (ph == 5)
        set_geometry($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom);
      else
        set_geometry($urandom_range(6, 1), $urandom_range(8, 1), $urandom_range(8, 1),
                     $urandom_range(8, 1), $urandom_range(4, 1), $urandom_range(4, 1),
                     $urandom_range(4), $urandom_range(4));
      if (ph == 3)
        set_reg(FIRST_SPARE_IDX + mp2d_pkg::CFG_IDX_W'($urandom_range(7)),
                mp2d_pkg::CFG_DATA_W'($urandom));
      repeat (PHASE_PIXELS) send_pixel(random_pixel());
      drain();
    end

    if (pool_sb.expected_windows.size() != 0) begin
      $error("%0d expected windows never arrived", pool_sb.expected_windows.size());
      pool_sb.errors++;
    end
    if (pool_sb.errors == 0)
      $display("max_pool_2d_stream_core regression: pass");
    else
      $display("max_pool_2d_stream_core regression: fail");
    $finish;
  end

endmodule
